// File: hw/rtl/ftbs_pkg.sv
// ftbs_pkg: shared types and constants of the flow token bucket sampler
// item structs, flow table entry layout, handshake status of the serial units
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ftbs_pkg;

    localparam int FLOWS         = 1024;
    localparam int MAX_COPY      = 1400;
    localparam int MS_PER_SECOND = 1000;
    localparam int HDR_IP_UDP    = 28;
    localparam int HDR_UDP       = 8;

    localparam int FLOW_IDX_W = 10;
    localparam int FLOW_AW    = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int TIME_W     = 48;
    localparam int LEN_W      = 16;
    localparam int RATE_W     = 16;
    localparam int TOK_W      = 16;
    localparam int CNT_W      = 32;
    localparam int FIELD11_W  = 11;

    localparam int WIN_W      = $clog2(MS_PER_SECOND + 1);
    localparam int REM_STEP_W = $clog2(CNT_W);
    localparam int WIN_STEP_W = $clog2(WIN_W);

    localparam logic [TOK_W-1:0] TOKEN_MAX = '1;

    typedef enum logic {
        REQ_PACKET = 1'b0,
        REQ_CLEAR  = 1'b1
    } t_req;

    typedef struct packed {
        t_req                req_type;
        logic [FLOW_IDX_W-1:0] flow_index;
        logic [TIME_W-1:0]   now_ms;
        logic                is_tcp;
        logic [LEN_W-1:0]    packet_len;
        logic [RATE_W-1:0]   sample_every;
        logic [RATE_W-1:0]   samples_per_second;
    } t_in_item;

    typedef struct packed {
        logic                 sample_taken;
        logic [FIELD11_W-1:0] copy_len;
        logic [FIELD11_W-1:0] ip_total_length;
        logic [FIELD11_W-1:0] udp_length;
        logic [TOK_W-1:0]     tokens_left;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]  packet_counter;
        logic [TOK_W-1:0]  token_count;
        logic [TIME_W-1:0] refill_time;
    } t_flow_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ser_sts;

endpackage

`default_nettype wire

// File: hw/rtl/ftbs_stream_if.sv
// ftbs_stream_if: valid/ready channels of the sampler, input and result side
// payload types come from ftbs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ftbs_in_if;
    import ftbs_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ftbs_out_if;
    import ftbs_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ftbs_flow_ram.sv
// ftbs_flow_ram: simple dual-port RAM, one write and one registered read per cycle
// generic, no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ftbs_flow_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 96
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output      logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/ftbs_rem_unit.sv
// ftbs_rem_unit: bit-serial restoring remainder of the packet counter by the rate
// one dividend bit per cycle; uses ftbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ftbs_rem_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ftbs_pkg::CNT_W-1:0]  i_dividend,
    input  wire logic [ftbs_pkg::RATE_W-1:0] i_divisor,
    output      ftbs_pkg::t_ser_sts          o_sts,
    output      logic [ftbs_pkg::RATE_W-1:0] o_rem
);
    import ftbs_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [REM_STEP_W-1:0] r_step;
    logic [CNT_W-1:0]      r_shift;
    logic [RATE_W-1:0]     r_rem;
    logic [RATE_W-1:0]     r_div;

    logic [RATE_W:0]   n_trial;
    logic              n_ge;
    logic [RATE_W-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_shift[CNT_W-1]};
        n_ge    = n_trial >= {1'b0, r_div};
        n_rem   = n_ge ? RATE_W'(n_trial - {1'b0, r_div}) : n_trial[RATE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_step  <= REM_STEP_W'(CNT_W - 1);
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[CNT_W-2:0], 1'b0};
            r_step  <= r_step - 1'b1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule

`default_nettype wire

// File: hw/rtl/ftbs_win_unit.sv
// ftbs_win_unit: bit-serial division of one second in ms by the token bound
// gives the refill window, at least 1 ms; uses ftbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ftbs_win_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ftbs_pkg::RATE_W-1:0] i_bound,
    output      ftbs_pkg::t_ser_sts          o_sts,
    output      logic [ftbs_pkg::WIN_W-1:0]  o_window
);
    import ftbs_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [WIN_STEP_W-1:0] r_step;
    logic [WIN_W-1:0]      r_shift;
    logic [RATE_W-1:0]     r_rem;
    logic [RATE_W-1:0]     r_div;

    logic [RATE_W:0]   n_trial;
    logic              n_ge;
    logic [RATE_W-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_shift[WIN_W-1]};
        n_ge    = n_trial >= {1'b0, r_div};
        n_rem   = n_ge ? RATE_W'(n_trial - {1'b0, r_div}) : n_trial[RATE_W-1:0];
    end

    // quotient bits shift in behind the dividend bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_step  <= WIN_STEP_W'(WIN_W - 1);
            r_shift <= WIN_W'(MS_PER_SECOND);
            r_rem   <= '0;
            r_div   <= i_bound;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[WIN_W-2:0], n_ge};
            r_step  <= r_step - 1'b1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    // zero bound or bound above one second both give a 1 ms window
    assign o_window   = (r_div == '0 || r_shift == '0) ? WIN_W'(1) : r_shift;

endmodule

`default_nettype wire

// File: hw/rtl/flow_token_bucket_sampler.sv
// flow_token_bucket_sampler: top level, flow table, sequencer and result register
// uses ftbs_pkg, ftbs_stream_if, ftbs_flow_ram, ftbs_rem_unit, ftbs_win_unit
`timescale 1ns / 1ps
`default_nettype none

// Per-flow token bucket 1-in-N sampler. Each input item either clears one
// flow's entry or reports one packet of it, and gives exactly one result item.
// After reset the flow table is cleared one entry per cycle, with the input
// held not ready. Items are taken one at a time. A TCP packet item goes from
// acceptance through the read, calc and done states to a result in the output
// register; calc lasts for the 32-step bit-serial remainder of the flow's
// packet counter by its rate (the 10-step refill window division runs beside
// it). Clear, non-TCP and out-of-range items skip calc. Done holds while the
// output register stays full. The flow table is one RAM with a registered read;
// a finished result waits in the output register while the next is accepted.
module flow_token_bucket_sampler (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ftbs_in_if.sink     i_in,
    ftbs_out_if.source  o_out
);
    import ftbs_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CALC,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [FLOW_AW-1:0]  r_clr_addr;
    t_in_item            r_item;
    logic [FLOW_AW-1:0]  r_addr;
    logic                r_in_range;
    t_flow_entry         r_entry;
    logic [TIME_W-1:0]   r_elapsed;
    logic                r_start;
    t_out_item           r_res;
    logic                r_wr_en;
    t_flow_entry         r_wr_entry;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [$bits(t_flow_entry)-1:0] w_rd_bits;
    logic [$bits(t_flow_entry)-1:0] w_wr_bits;
    t_flow_entry         w_rd_entry;
    logic                w_we;
    logic [FLOW_AW-1:0]  w_waddr;
    logic                w_accept;
    logic                w_out_free;
    t_ser_sts            w_rem_sts;
    t_ser_sts            w_win_sts;
    logic [RATE_W-1:0]   w_rem;
    logic [WIN_W-1:0]    w_window;
    logic                w_calc_done;
    logic                w_refill;
    logic [TOK_W-1:0]    w_tok1;
    logic                w_take;
    logic [TOK_W-1:0]    w_tok2;
    logic [LEN_W-1:0]    w_copy;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_rd_entry = t_flow_entry'(w_rd_bits);

    assign w_we      = (r_state == S_CLEAR) || (r_state == S_DONE && w_out_free && r_wr_en);
    assign w_waddr   = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign w_wr_bits = (r_state == S_CLEAR) ? '0 : r_wr_entry;

    ftbs_flow_ram #(
        .DEPTH (FLOWS),
        .AW    (FLOW_AW),
        .DW    ($bits(t_flow_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr_bits),
        .i_raddr (FLOW_AW'(i_in.data.flow_index)),
        .o_rdata (w_rd_bits)
    );

    ftbs_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_entry.packet_counter),
        .i_divisor  (r_item.sample_every),
        .o_sts      (w_rem_sts),
        .o_rem      (w_rem)
    );

    ftbs_win_unit u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_bound  (r_item.samples_per_second),
        .o_sts    (w_win_sts),
        .o_window (w_window)
    );

    always_comb begin
        w_calc_done = !r_start && w_rem_sts.done && w_win_sts.done;
        w_refill    = (|r_elapsed[TIME_W-1:WIN_W]) || (r_elapsed[WIN_W-1:0] >= w_window);
        w_tok1      = (w_refill && r_entry.token_count != TOKEN_MAX)
                      ? r_entry.token_count + 1'b1 : r_entry.token_count;
        w_take      = (r_item.sample_every != '0) && (w_rem == '0) && (w_tok1 != '0);
        w_tok2      = w_take ? w_tok1 - 1'b1 : w_tok1;
        w_copy      = (r_item.packet_len > LEN_W'(MAX_COPY)) ? LEN_W'(MAX_COPY)
                                                             : r_item.packet_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == FLOW_AW'(FLOWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_item     <= i_in.data;
                        r_addr     <= FLOW_AW'(i_in.data.flow_index);
                        r_in_range <= 17'(i_in.data.flow_index) < 17'(FLOWS);
                        r_state    <= S_READ;
                    end
                end
                S_READ: begin
                    if (!r_in_range) begin
                        r_res   <= '0;
                        r_wr_en <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_item.req_type == REQ_CLEAR) begin
                        r_res      <= '0;
                        r_wr_en    <= 1'b1;
                        r_wr_entry <= '0;
                        r_state    <= S_DONE;
                    end else if (!r_item.is_tcp) begin
                        r_res   <= '{sample_taken: 1'b0, copy_len: '0, ip_total_length: '0,
                                     udp_length: '0, tokens_left: w_rd_entry.token_count};
                        r_wr_en <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_wr_en                <= 1'b0;
                        r_entry.packet_counter <= w_rd_entry.packet_counter + 1'b1;
                        r_entry.token_count    <= w_rd_entry.token_count;
                        r_entry.refill_time    <= w_rd_entry.refill_time;
                        r_elapsed <= r_item.now_ms - w_rd_entry.refill_time;
                        r_start   <= 1'b1;
                        r_state   <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_start <= 1'b0;
                    if (w_calc_done) begin
                        r_res.sample_taken    <= w_take;
                        r_res.copy_len        <= w_take ? FIELD11_W'(w_copy) : '0;
                        r_res.ip_total_length <= w_take
                            ? FIELD11_W'(w_copy + LEN_W'(HDR_IP_UDP)) : '0;
                        r_res.udp_length      <= w_take
                            ? FIELD11_W'(w_copy + LEN_W'(HDR_UDP)) : '0;
                        r_res.tokens_left     <= w_tok2;
                        r_wr_en                   <= 1'b1;
                        r_wr_entry.packet_counter <= r_entry.packet_counter;
                        r_wr_entry.token_count    <= w_tok2;
                        r_wr_entry.refill_time    <= w_refill ? r_item.now_ms
                                                              : r_entry.refill_time;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef NO_ASSERTIONS
    a_no_sample_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.sample_taken) |->
        (o_out.data.copy_len == '0 && o_out.data.ip_total_length == '0 &&
         o_out.data.udp_length == '0))
        else $error("length fields set without a sample");

    a_hdr_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.sample_taken) |->
        (o_out.data.udp_length == FIELD11_W'(o_out.data.copy_len + FIELD11_W'(HDR_UDP)) &&
         o_out.data.ip_total_length ==
             FIELD11_W'(o_out.data.copy_len + FIELD11_W'(HDR_IP_UDP))))
        else $error("header length fields do not match copy length");

    a_clear_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !i_in.ready)
        else $error("input ready before flow table clear pass");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || (r_state == S_DONE && w_out_free)))
        else $error("flow table written outside clear pass or result load");

    a_units_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (!w_rem_sts.busy && !w_win_sts.busy))
        else $error("item accepted while a serial unit is busy");
`endif

endmodule

`default_nettype wire
